[hdl/ccmt_pkg.sv]
// ccmt_pkg: shared types and fixed port widths for the circle center merge table
// no dependencies; used by circle_center_merge_table
`default_nettype none

package ccmt_pkg;

    // fixed widths of the payload ports
    localparam int COORD_PORT_W = 12;
    localparam int SLOT_PORT_W  = 6;
    localparam int COUNT_PORT_W = 7;
    localparam int MERGE_W      = 26;

    localparam logic [MERGE_W-1:0] MERGE_RESET = MERGE_W'(100);

    // input operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[hdl/ccmt_ram.sv]
// ccmt_ram: generic simple dual-port ram with one write and one registered read port
// no dependencies; used by circle_center_merge_table for the circle table
`default_nettype none

module ccmt_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hdl/circle_center_merge_table.sv]
// circle_center_merge_table: table of detected circles that merges close detections
// depends on ccmt_pkg and ccmt_ram
//
// Usage: an input transfer carries op, a circle (x, y, r) and last_circle. An insert
// scans the valid entries in index order; the first one whose squared center
// distance is at most merge_dist_sq is replaced by the truncated mean of old and new.
// Otherwise the circle is appended, or dropped with a flag when the table is full.
// A clear empties the table. Every input transfer yields exactly one result transfer.
// An insert runs a scan that reads one table entry per cycle from the ram into a
// two stage distance pipeline; a clear skips the scan. One item is in work at a
// time, and the input stall is high while an item is in work. The result sits in
// an output register: the next item is accepted while it waits, and its own
// result waits for the register to free up. Reset clears the entry count, the
// output valid and sets merge_dist_sq to 100; the table contents need no
// clearing. The user must write merge_dist_sq only while idle; the block itself
// does not enforce it.
`default_nettype none

module circle_center_merge_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int COORD_BITS    = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [ccmt_pkg::MERGE_W-1:0]      i_cfg_data,
    // input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_op,
    input  wire logic [ccmt_pkg::COORD_PORT_W-1:0] i_circle_x,
    input  wire logic [ccmt_pkg::COORD_PORT_W-1:0] i_circle_y,
    input  wire logic [ccmt_pkg::COORD_PORT_W-1:0] i_circle_r,
    input  wire logic                              i_last_circle,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [ccmt_pkg::SLOT_PORT_W-1:0]       o_slot,
    output logic                                   o_merged,
    output logic                                   o_dropped,
    output logic [ccmt_pkg::COORD_PORT_W-1:0]      o_entry_x,
    output logic [ccmt_pkg::COORD_PORT_W-1:0]      o_entry_y,
    output logic [ccmt_pkg::COORD_PORT_W-1:0]      o_entry_r,
    output logic [ccmt_pkg::COUNT_PORT_W-1:0]      o_entry_count,
    output logic                                   o_batch_done
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int MW     = ccmt_pkg::MERGE_W;
    localparam int CPW    = ccmt_pkg::COORD_PORT_W;
    localparam int SPW    = ccmt_pkg::SLOT_PORT_W;
    localparam int NPW    = ccmt_pkg::COUNT_PORT_W;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int D2_W   = SQ_W + 1;
    localparam int CMP_W  = (D2_W > MW) ? D2_W : MW;
    localparam int WORD_W = 3 * COORD_BITS;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

    ccmt_pkg::t_state r_state, n_state;

    logic [MW-1:0]         r_merge_dist_sq;
    logic [CNT_W-1:0]      r_count;

    // latched item
    logic [COORD_BITS-1:0] r_cx, r_cy, r_cr;
    logic                  r_last;

    // scan pipeline
    logic [CNT_W-1:0]      r_iss;
    logic                  r_s1_vld;
    logic [IDX_W-1:0]      r_s1_idx;
    logic                  r_s2_vld;
    logic [IDX_W-1:0]      r_s2_idx;
    logic [SQ_W-1:0]       r_sqx, r_sqy;
    logic [COORD_BITS-1:0] r_s2_x, r_s2_y, r_s2_r;

    // pending result
    logic [IDX_W-1:0]      r_res_slot;
    logic                  r_res_merged, r_res_dropped, r_res_wr;
    logic [COORD_BITS-1:0] r_res_x, r_res_y, r_res_r;
    logic [CNT_W-1:0]      r_res_count;

    logic                  in_xfer, issue, hit, miss, out_free;
    logic [WORD_W-1:0]     ram_rdata, ram_wdata;
    logic [COORD_BITS-1:0] rd_x, rd_y, rd_r;
    logic [COORD_BITS-1:0] dx, dy;
    logic [D2_W-1:0]       d2;
    logic [COORD_BITS:0]   sum_x, sum_y, sum_r;

    ccmt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (r_state == ccmt_pkg::ST_COMMIT && r_res_wr),
        .i_waddr (r_res_slot),
        .i_wdata (ram_wdata),
        .i_raddr (r_iss[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ram_wdata = {r_res_r, r_res_y, r_res_x};
    assign rd_x      = ram_rdata[COORD_BITS-1:0];
    assign rd_y      = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_r      = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];

    assign o_in_stall = (r_state != ccmt_pkg::ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;

    // stage 1: absolute differences against the entry just read
    assign dx = (r_cx >= rd_x) ? (r_cx - rd_x) : (rd_x - r_cx);
    assign dy = (r_cy >= rd_y) ? (r_cy - rd_y) : (rd_y - r_cy);

    // stage 2: sum of squares and compare
    assign d2    = D2_W'(r_sqx) + D2_W'(r_sqy);
    assign hit   = r_s2_vld && (CMP_W'(d2) <= CMP_W'(r_merge_dist_sq));
    assign issue = (r_state == ccmt_pkg::ST_SCAN) && (r_iss < r_count) && !hit;
    assign miss  = (r_state == ccmt_pkg::ST_SCAN) && !r_s1_vld && !r_s2_vld
                   && (r_iss == r_count);

    assign sum_x = (COORD_BITS+1)'(r_s2_x) + (COORD_BITS+1)'(r_cx);
    assign sum_y = (COORD_BITS+1)'(r_s2_y) + (COORD_BITS+1)'(r_cy);
    assign sum_r = (COORD_BITS+1)'(r_s2_r) + (COORD_BITS+1)'(r_cr);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ccmt_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_op == ccmt_pkg::OP_CLEAR) ? ccmt_pkg::ST_COMMIT
                                                           : ccmt_pkg::ST_SCAN;
                end
            end
            ccmt_pkg::ST_SCAN: begin
                if (hit || miss) begin
                    n_state = ccmt_pkg::ST_COMMIT;
                end
            end
            ccmt_pkg::ST_COMMIT: begin
                n_state = ccmt_pkg::ST_OUT;
            end
            ccmt_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = ccmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ccmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ccmt_pkg::ST_IDLE;
            r_merge_dist_sq <= ccmt_pkg::MERGE_RESET;
            r_count         <= '0;
            r_s1_vld        <= 1'b0;
            r_s2_vld        <= 1'b0;
            o_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_merge_dist_sq <= i_cfg_data;
            end
            if (r_state == ccmt_pkg::ST_SCAN && !hit && !miss) begin
                r_s1_vld <= issue;
                r_s2_vld <= r_s1_vld;
            end else begin
                r_s1_vld <= 1'b0;
                r_s2_vld <= 1'b0;
            end
            if (r_state == ccmt_pkg::ST_COMMIT) begin
                r_count <= r_res_count;
            end
            if (r_state == ccmt_pkg::ST_OUT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cx   <= COORD_BITS'(i_circle_x);
            r_cy   <= COORD_BITS'(i_circle_y);
            r_cr   <= COORD_BITS'(i_circle_r);
            r_last <= i_last_circle;
            r_iss  <= '0;
            if (i_op == ccmt_pkg::OP_CLEAR) begin
                r_res_slot    <= '0;
                r_res_merged  <= 1'b0;
                r_res_dropped <= 1'b0;
                r_res_wr      <= 1'b0;
                r_res_x       <= '0;
                r_res_y       <= '0;
                r_res_r       <= '0;
                r_res_count   <= '0;
            end
        end
        if (issue) begin
            r_iss <= r_iss + CNT_W'(1);
        end
        r_s1_idx <= r_iss[IDX_W-1:0];
        r_s2_idx <= r_s1_idx;
        r_sqx    <= SQ_W'(dx) * SQ_W'(dx);
        r_sqy    <= SQ_W'(dy) * SQ_W'(dy);
        r_s2_x   <= rd_x;
        r_s2_y   <= rd_y;
        r_s2_r   <= rd_r;
        if (hit) begin
            r_res_slot    <= r_s2_idx;
            r_res_merged  <= 1'b1;
            r_res_dropped <= 1'b0;
            r_res_wr      <= 1'b1;
            r_res_x       <= sum_x[COORD_BITS:1];
            r_res_y       <= sum_y[COORD_BITS:1];
            r_res_r       <= sum_r[COORD_BITS:1];
            r_res_count   <= r_count;
        end else if (miss) begin
            r_res_merged <= 1'b0;
            r_res_count  <= (r_count == FULL) ? r_count : r_count + CNT_W'(1);
            if (r_count == FULL) begin
                // table full: nothing stored
                r_res_slot    <= '0;
                r_res_dropped <= 1'b1;
                r_res_wr      <= 1'b0;
                r_res_x       <= '0;
                r_res_y       <= '0;
                r_res_r       <= '0;
            end else begin
                r_res_slot    <= r_count[IDX_W-1:0];
                r_res_dropped <= 1'b0;
                r_res_wr      <= 1'b1;
                r_res_x       <= r_cx;
                r_res_y       <= r_cy;
                r_res_r       <= r_cr;
            end
        end
        if (r_state == ccmt_pkg::ST_OUT && out_free) begin
            o_slot        <= SPW'(r_res_slot);
            o_merged      <= r_res_merged;
            o_dropped     <= r_res_dropped;
            o_entry_x     <= CPW'(r_res_x);
            o_entry_y     <= CPW'(r_res_y);
            o_entry_r     <= CPW'(r_res_r);
            o_entry_count <= NPW'(r_count);
            o_batch_done  <= r_last;
        end
    end

endmodule

`default_nettype wire
